// ===== src/atfb_pkg.sv =====
// Package for the API transmit frame builder: beat types, queue entry,
// configuration snapshot, register indexes and frame phase codes. No dependencies.
package atfb_pkg;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_START_DELIM = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_ADDR   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_TAG   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TX_OPTIONS  = 8'd3;

   // Register reset values
   localparam logic [7:0]  RST_START_DELIM = 8'h7E;
   localparam logic [63:0] RST_DEST_ADDR   = 64'd0;
   localparam logic [7:0]  RST_FRAME_TAG   = 8'h00;
   localparam logic [7:0]  RST_TX_OPTIONS  = 8'h01;

   // Frame constants
   localparam logic [7:0]  FRAME_TYPE   = 8'h00;
   localparam logic [15:0] LEN_OVERHEAD = 16'd11;
   localparam logic [7:0]  CHECK_BASE   = 8'hFF;

   // Default sizes
   localparam int unsigned DEFAULT_MAX_PAYLOAD = 100;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

   // Phase of the output sequencer within one queue entry
   localparam int unsigned PH_W = 4;
   localparam logic [PH_W-1:0] PH_DELIM   = 4'd0;
   localparam logic [PH_W-1:0] PH_LEN_HI  = 4'd1;
   localparam logic [PH_W-1:0] PH_LEN_LO  = 4'd2;
   localparam logic [PH_W-1:0] PH_TYPE    = 4'd3;
   localparam logic [PH_W-1:0] PH_ID      = 4'd4;
   localparam logic [PH_W-1:0] PH_DEST0   = 4'd5;
   localparam logic [PH_W-1:0] PH_DEST7   = 4'd12;
   localparam logic [PH_W-1:0] PH_OPTIONS = 4'd13;
   localparam logic [PH_W-1:0] PH_PAYLOAD = 4'd14;
   localparam logic [PH_W-1:0] PH_CHECK   = 4'd15;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [6:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       run_last;
      logic       frame_end;
   } rsp_type;

   // One classified payload byte waiting for the back end
   typedef struct packed {
      logic [7:0] payload_byte;
      logic [6:0] length;
      logic       is_first;
      logic       is_last;
   } entry_type;

   typedef struct packed {
      logic [7:0]  start_delim;
      logic [63:0] dest_address;
      logic [7:0]  frame_tag;
      logic [7:0]  tx_options;
   } cfg_type;

endpackage

// ===== src/atfb_front.sv =====
// Front end: accepts payload beats, tracks bytes left in the frame and
// classifies each beat as first and/or last. Depends on atfb_pkg.
module atfb_front import atfb_pkg::*; #(
   parameter int unsigned MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  logic      queue_full,
   output logic      push,
   output entry_type push_entry
);
   localparam int unsigned MaxClamp = (MAX_PAYLOAD > 127) ? 127 : MAX_PAYLOAD;
   localparam logic [6:0] MaxLen = 7'(MaxClamp);

   logic [6:0] left_ff, left_in;
   logic [6:0] len_eff;
   logic       first;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign first     = (left_ff == 7'd0);

   always_comb begin
      len_eff = req_data.payload_length;
      if (len_eff == 7'd0) begin
         len_eff = 7'd1;
      end
      if (len_eff > MaxLen) begin
         len_eff = MaxLen;
      end
      left_in = first ? (len_eff - 7'd1) : (left_ff - 7'd1);
      push_entry.payload_byte = req_data.payload_byte;
      push_entry.length       = len_eff;
      push_entry.is_first     = first;
      push_entry.is_last      = (left_in == 7'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 7'd0;
      end else if (push) begin
         left_ff <= left_in;
      end
   end
endmodule

// ===== src/atfb_fifo.sv =====
// Short queue of classified entries between front and back.
// Depends on atfb_pkg.
module atfb_fifo import atfb_pkg::*; #(
   parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  entry_type     push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output entry_type     head
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

   entry_type     mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end
endmodule

// ===== src/atfb_back.sv =====
// Back end: steps through the header (first entry of a frame), payload and checksum (last
// entry of a frame) bytes of each queue entry into a registered output beat. Depends on atfb_pkg.
module atfb_back import atfb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  entry_type     head,
   input  cfg_type       cfg,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);
   logic [PH_W-1:0] ph_ff, ph_in, eff;
   logic [7:0]      sum_ff, sum_in;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff, rsp_data_in;
   logic            adv, fire, done;
   logic [7:0]      out_byte;
   logic [15:0]     flen;
   logic [2:0]      dk;

   assign adv  = !rsp_valid_ff || rsp_ready;
   assign fire = adv && head_valid;
   // Non-first entries skip straight to the payload phase
   assign eff  = (ph_ff == PH_DELIM && !head.is_first) ? PH_PAYLOAD : ph_ff;
   assign flen = 16'(head.length) + LEN_OVERHEAD;
   assign dk   = 3'(eff - PH_DEST0);
   assign done = (eff == PH_PAYLOAD && !head.is_last) || (eff == PH_CHECK);
   assign pop  = fire && done;

   always_comb begin
      sum_in = sum_ff;
      unique case (eff) inside
         PH_DELIM:            out_byte = cfg.start_delim;
         PH_LEN_HI:           out_byte = flen[15:8];
         PH_LEN_LO:           out_byte = flen[7:0];
         PH_TYPE:             out_byte = FRAME_TYPE;
         PH_ID:               out_byte = cfg.frame_tag;
         [PH_DEST0:PH_DEST7]: out_byte = cfg.dest_address[{~dk, 3'b000} +: 8];
         PH_OPTIONS:          out_byte = cfg.tx_options;
         PH_PAYLOAD:          out_byte = head.payload_byte;
         PH_CHECK:            out_byte = CHECK_BASE - sum_ff;
         default:             out_byte = head.payload_byte;
      endcase
      case (eff) inside
         PH_DELIM, PH_CHECK:    sum_in = 8'd0;
         [PH_TYPE:PH_PAYLOAD]:  sum_in = sum_ff + out_byte;
         default:               sum_in = sum_ff;
      endcase
      ph_in                = done ? PH_DELIM : eff + PH_W'(1);
      rsp_data_in.frame_byte = out_byte;
      rsp_data_in.run_last   = done;
      rsp_data_in.frame_end  = (eff == PH_CHECK);
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ph_ff        <= PH_DELIM;
         sum_ff       <= 8'd0;
      end else begin
         if (adv) begin
            rsp_valid_ff <= head_valid;
         end
         if (fire) begin
            ph_ff  <= ph_in;
            sum_ff <= sum_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== src/api_tx_frame_builder.sv =====
// API transmit frame builder: an accepted beat goes through the queue to the output register.
// Throughput: 1 payload beat per cycle mid-frame while rsp_ready is high; a frame's first
// beat also emits the header bytes and its last beat the checksum, via the output register.
// Reset (synchronous, active high) empties the queue, drops any frame in flight and
// restores the registers: delimiter 0x7E, destination 0, frame id 0, options 0x01.
// Depends on atfb_pkg, atfb_front, atfb_fifo and atfb_back.
module api_tx_frame_builder import atfb_pkg::*; #(
   parameter int unsigned MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD,
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_wdata
);
   cfg_type       cfg_ff;
   logic          push, full, pop;
   entry_type     push_entry, head;
   logic          head_valid;

   // Configuration: always ready, unknown indexes drop the beat
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delim  <= RST_START_DELIM;
         cfg_ff.dest_address <= RST_DEST_ADDR;
         cfg_ff.frame_tag    <= RST_FRAME_TAG;
         cfg_ff.tx_options   <= RST_TX_OPTIONS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_START_DELIM: cfg_ff.start_delim  <= csr_wdata[7:0];
            REG_DEST_ADDR:   cfg_ff.dest_address <= csr_wdata;
            REG_FRAME_TAG:   cfg_ff.frame_tag    <= csr_wdata[7:0];
            REG_TX_OPTIONS:  cfg_ff.tx_options   <= csr_wdata[7:0];
            default:         ;
         endcase
      end
   end

   // Front: classify each payload beat, stall only when the queue is full
   atfb_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue: decouple input stalls from header emission
   atfb_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Back: serialize header, payload and checksum, one beat per cycle while rsp_ready allows
   atfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .cfg        (cfg_ff),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );
endmodule

// ===== src/atfb_checker.sv =====
// Port-level checks for the API transmit frame builder, bound to the top level.
// Depends on atfb_pkg.
module atfb_checker import atfb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data,
   input logic    csr_ready
);
   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // Checksum beat always closes its input's results
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.run_last)
      else $error("checksum beat without run_last");

   // Drop any result after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // Configuration never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr_ready low");
endmodule

bind api_tx_frame_builder atfb_checker u_atfb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
